>>> sv/fmp_pkg.sv
// Shared types, constants and float compare helpers for the fractional max pool block.
// Used by the controller, the datapath and the top level; depends on nothing.
package fmp_pkg;

    localparam int SIZE_W = 7;
    localparam int IDX_W  = 12;
    localparam int DVD_W  = 13;
    localparam int DIV_W  = 7;

    localparam logic [31:0] NEG_INF = 32'hFF800000;

    localparam logic [2:0] CFG_IN_HEIGHT  = 3'd0;
    localparam logic [2:0] CFG_IN_WIDTH   = 3'd1;
    localparam logic [2:0] CFG_OUT_HEIGHT = 3'd2;
    localparam logic [2:0] CFG_OUT_WIDTH  = 3'd3;
    localparam logic [2:0] CFG_WIN_HEIGHT = 3'd4;
    localparam logic [2:0] CFG_WIN_WIDTH  = 3'd5;

    localparam logic [1:0] DSEL_N1H = 2'd0;
    localparam logic [1:0] DSEL_N2H = 2'd1;
    localparam logic [1:0] DSEL_N1W = 2'd2;
    localparam logic [1:0] DSEL_N2W = 2'd3;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef struct packed {
        logic       load_wr;
        logic       capture;
        logic       mul;
        logic       div_start;
        logic       div_store;
        logic [1:0] div_sel;
        logic       base;
        logic       scan;
        logic       emit;
    } fmp_cmd_t;

    typedef struct packed {
        logic div_done;
        logic scan_last;
        logic out_full;
    } fmp_status_t;

    function automatic logic f32_is_nan(input logic [31:0] x);
        f32_is_nan = (x[30:0] > 31'h7F800000);
    endfunction

    function automatic logic [31:0] f32_key(input logic [31:0] x);
        f32_key = x[31] ? ~x : (x | 32'h80000000);
    endfunction

    // replace the running maximum: any NaN, or strictly greater ordered value
    function automatic logic f32_take(input logic [31:0] v, input logic [31:0] m);
        logic gt;
        gt = 1'b0;
        if (!f32_is_nan(v) && !f32_is_nan(m) && !(v[30:0] == '0 && m[30:0] == '0))
        begin
            gt = f32_key(v) > f32_key(m);
        end
        f32_take = f32_is_nan(v) || gt;
    endfunction

    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                     input logic [SIZE_W-1:0] cap);
        if (v == '0)
        begin
            clamp_size = SIZE_W'(1);
        end
        else if (v > cap)
        begin
            clamp_size = cap;
        end
        else
        begin
            clamp_size = v;
        end
    endfunction

endpackage

>>> sv/fmp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fmp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/fmp_div.sv
// Restoring serial divider, one quotient bit per cycle.
// Depends on fmp_pkg for the operand widths.
module fmp_div
    import fmp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DIV_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DVD_W);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0] rem_reg, rem_next;
    logic [DVD_W-1:0] quo_reg, quo_next;
    logic [DIV_W:0]   rem_sh;
    logic             ge;

    always_comb
    begin
        rem_sh    = {rem_reg, quo_reg[DVD_W-1]};
        ge        = rem_sh >= {1'b0, divisor};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? DIV_W'(rem_sh - {1'b0, divisor}) : rem_sh[DIV_W-1:0];
            quo_next = {quo_reg[DVD_W-2:0], ge};
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(DVD_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

>>> sv/fmp_datapath.sv
// Datapath: configuration registers, plane store, window start arithmetic and window scan.
// Depends on fmp_pkg, fmp_ram and fmp_div; driven by fmp_ctrl commands.
module fmp_datapath
    import fmp_pkg::*;
#(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [6:0]  cfg_wdata,
    input  logic [5:0]  pixel_row,
    input  logic [5:0]  pixel_col,
    input  logic [31:0] pixel_value,
    input  logic [5:0]  out_row,
    input  logic [5:0]  out_col,
    input  logic [15:0] sample_h,
    input  logic [15:0] sample_w,
    input  fmp_cmd_t    cmd,
    output fmp_status_t status,
    input  logic        out_ready,
    output logic        out_valid,
    output logic [31:0] max_value,
    output logic [11:0] max_index
);

    localparam int AW = $clog2(MAX_ROWS * MAX_COLS);
    localparam logic [SIZE_W-1:0] ROW_CAP = (MAX_ROWS > 127) ? 7'd127 : SIZE_W'(MAX_ROWS);
    localparam logic [SIZE_W-1:0] COL_CAP = (MAX_COLS > 127) ? 7'd127 : SIZE_W'(MAX_COLS);

    logic [SIZE_W-1:0] in_height_reg, in_width_reg, out_height_reg, out_width_reg;
    logic [SIZE_W-1:0] win_height_reg, win_width_reg;
    logic [SIZE_W-1:0] ih, iw, oh, ow, kh, kw, span_h, span_w, dh, dw, sh, sw;

    logic [5:0]        qrow_reg, qcol_reg;
    logic [15:0]       samp_h_reg, samp_w_reg;
    logic              last_h_reg, last_w_reg;
    logic [DVD_W-1:0]  n1h_reg, n1w_reg;
    logic [DIV_W-1:0]  n2h_reg, n2w_reg;
    logic [DVD_W-1:0]  q1h_reg, q2h_reg, q1w_reg, q2w_reg;
    logic [28:0]       prod1h, prod1w;
    logic [22:0]       prod2h, prod2w;

    logic [DVD_W-1:0]  dvd;
    logic [DIV_W-1:0]  dvs;
    logic              div_done;
    logic [DVD_W-1:0]  quo;

    logic [SIZE_W-1:0] sw_reg, hc_reg, wc_reg;
    logic [IDX_W-1:0]  row_idx_reg, pipe_idx_reg, midx_reg;
    logic [AW-1:0]     ram_row_reg;
    logic              rd_valid_reg;
    logic [31:0]       max_reg;
    logic [13:0]       sh_iw;
    logic [31:0]       sh_row, load_addr;

    logic              load_ok;
    logic [AW-1:0]     raddr;
    logic [31:0]       rdata;

    logic              out_valid_reg;
    logic [31:0]       out_value_reg;
    logic [IDX_W-1:0]  out_index_reg;

    always_comb
    begin
        ih     = clamp_size(in_height_reg, ROW_CAP);
        iw     = clamp_size(in_width_reg, COL_CAP);
        oh     = clamp_size(out_height_reg, 7'd127);
        ow     = clamp_size(out_width_reg, 7'd127);
        kh     = clamp_size(win_height_reg, ih);
        kw     = clamp_size(win_width_reg, iw);
        span_h = ih - kh;
        span_w = iw - kw;
        dh     = oh - 7'd1;
        dw     = ow - 7'd1;
        prod1h = 29'({qrow_reg, samp_h_reg}) * 29'(span_h);
        prod1w = 29'({qcol_reg, samp_w_reg}) * 29'(span_w);
        prod2h = 23'(samp_h_reg) * 23'(span_h);
        prod2w = 23'(samp_w_reg) * 23'(span_w);
        sh     = last_h_reg ? span_h : SIZE_W'(q1h_reg - q2h_reg);
        sw     = last_w_reg ? span_w : SIZE_W'(q1w_reg - q2w_reg);
        sh_iw  = 14'(sh) * 14'(iw);
        sh_row = 32'(sh) * 32'(MAX_COLS);
        case (cmd.div_sel)
            DSEL_N1H: dvd = n1h_reg;
            DSEL_N2H: dvd = DVD_W'(n2h_reg);
            DSEL_N1W: dvd = n1w_reg;
            DSEL_N2W: dvd = DVD_W'(n2w_reg);
            default:  dvd = n1h_reg;
        endcase
        dvs       = cmd.div_sel[1] ? dw : dh;
        load_ok   = (32'(pixel_row) < MAX_ROWS) && (32'(pixel_col) < MAX_COLS);
        load_addr = 32'(pixel_row) * 32'(MAX_COLS) + 32'(pixel_col);
        raddr     = ram_row_reg + AW'(sw_reg) + AW'(wc_reg);
    end

    fmp_ram #(
        .WIDTH (32),
        .DEPTH (MAX_ROWS * MAX_COLS)
    ) u_ram (
        .clk   (clk),
        .we    (cmd.load_wr && load_ok),
        .waddr (load_addr[AW-1:0]),
        .wdata (pixel_value),
        .re    (cmd.scan),
        .raddr (raddr),
        .rdata (rdata)
    );

    fmp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (dvd),
        .divisor  (dvs),
        .done     (div_done),
        .quotient (quo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_height_reg  <= 7'd64;
            in_width_reg   <= 7'd64;
            out_height_reg <= 7'd32;
            out_width_reg  <= 7'd32;
            win_height_reg <= 7'd2;
            win_width_reg  <= 7'd2;
            rd_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_addr)
                    CFG_IN_HEIGHT:  in_height_reg  <= cfg_wdata;
                    CFG_IN_WIDTH:   in_width_reg   <= cfg_wdata;
                    CFG_OUT_HEIGHT: out_height_reg <= cfg_wdata;
                    CFG_OUT_WIDTH:  out_width_reg  <= cfg_wdata;
                    CFG_WIN_HEIGHT: win_height_reg <= cfg_wdata;
                    CFG_WIN_WIDTH:  win_width_reg  <= cfg_wdata;
                    default:        ;
                endcase
            end
            rd_valid_reg <= cmd.scan;
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            qrow_reg   <= out_row;
            qcol_reg   <= out_col;
            samp_h_reg <= sample_h;
            samp_w_reg <= sample_w;
        end
        if (cmd.mul)
        begin
            last_h_reg <= {1'b0, qrow_reg} >= dh;
            last_w_reg <= {1'b0, qcol_reg} >= dw;
            n1h_reg    <= prod1h[28:16];
            n1w_reg    <= prod1w[28:16];
            n2h_reg    <= prod2h[22:16];
            n2w_reg    <= prod2w[22:16];
        end
        if (cmd.div_store)
        begin
            case (cmd.div_sel)
                DSEL_N1H: q1h_reg <= quo;
                DSEL_N2H: q2h_reg <= quo;
                DSEL_N1W: q1w_reg <= quo;
                DSEL_N2W: q2w_reg <= quo;
                default:  ;
            endcase
        end
        if (cmd.base)
        begin
            sw_reg      <= sw;
            hc_reg      <= '0;
            wc_reg      <= '0;
            row_idx_reg <= sh_iw[IDX_W-1:0];
            ram_row_reg <= sh_row[AW-1:0];
            max_reg     <= NEG_INF;
            midx_reg    <= sh_iw[IDX_W-1:0] + IDX_W'(sw);
        end
        else
        begin
            if (cmd.scan)
            begin
                pipe_idx_reg <= row_idx_reg + IDX_W'(sw_reg) + IDX_W'(wc_reg);
                if (wc_reg == kw - 7'd1)
                begin
                    wc_reg      <= '0;
                    hc_reg      <= hc_reg + 7'd1;
                    ram_row_reg <= ram_row_reg + AW'(MAX_COLS);
                    row_idx_reg <= row_idx_reg + IDX_W'(iw);
                end
                else
                begin
                    wc_reg <= wc_reg + 7'd1;
                end
            end
            if (rd_valid_reg && f32_take(rdata, max_reg))
            begin
                max_reg  <= rdata;
                midx_reg <= pipe_idx_reg;
            end
        end
        if (cmd.emit)
        begin
            out_value_reg <= max_reg;
            out_index_reg <= midx_reg;
        end
    end

    assign status.div_done  = div_done;
    assign status.scan_last = (hc_reg == kh - 7'd1) && (wc_reg == kw - 7'd1);
    assign status.out_full  = out_valid_reg && !out_ready;

    assign out_valid = out_valid_reg;
    assign max_value = out_value_reg;
    assign max_index = out_index_reg;

endmodule

>>> sv/fmp_ctrl.sv
// Controller: sequences load writes, window start arithmetic, the scan and the result hand-off.
// Depends on fmp_pkg; drives fmp_datapath through command and status structs.
module fmp_ctrl
    import fmp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_kind,
    output logic        in_ready,
    input  fmp_status_t status,
    output fmp_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_BASE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } state_t;

    state_t     state_reg;
    logic [1:0] sel_reg;
    logic       accept;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        cmd           = '0;
        cmd.div_sel   = sel_reg;
        cmd.load_wr   = accept && (in_kind == KIND_LOAD);
        cmd.capture   = accept && (in_kind == KIND_QUERY);
        cmd.mul       = (state_reg == ST_MUL);
        cmd.div_start = (state_reg == ST_DIV_START);
        cmd.div_store = (state_reg == ST_DIV_WAIT) && status.div_done;
        cmd.base      = (state_reg == ST_BASE);
        cmd.scan      = (state_reg == ST_SCAN);
        cmd.emit      = (state_reg == ST_DONE) && !status.out_full;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            sel_reg   <= DSEL_N1H;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept && in_kind == KIND_QUERY)
                    begin
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL:
                begin
                    sel_reg   <= DSEL_N1H;
                    state_reg <= ST_DIV_START;
                end
                ST_DIV_START:
                begin
                    state_reg <= ST_DIV_WAIT;
                end
                ST_DIV_WAIT:
                begin
                    if (status.div_done)
                    begin
                        if (sel_reg == DSEL_N2W)
                        begin
                            state_reg <= ST_BASE;
                        end
                        else
                        begin
                            sel_reg   <= sel_reg + 2'd1;
                            state_reg <= ST_DIV_START;
                        end
                    end
                end
                ST_BASE:
                begin
                    state_reg <= ST_SCAN;
                end
                ST_SCAN:
                begin
                    if (status.scan_last)
                    begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN:
                begin
                    state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (!status.out_full)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

>>> sv/fractional_max_pool_2d_forward.sv
// Fractional max pooling, 2-D forward, over one stored binary32 feature plane.
// A load request (tuser 0) writes one pixel and returns nothing. A query request (tuser 1)
// runs four serial 13-bit divisions to set the window start, and the scan reads one pixel
// per cycle from the single read port of the plane store. A finished result waits in an
// output register while loads continue. Reading a pixel never loaded gives an undefined value.
// Depends on fmp_pkg, fmp_ctrl and fmp_datapath.
module fractional_max_pool_2d_forward
    import fmp_pkg::*;
#(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [6:0]  cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // pixel_row, pixel_col, pixel_value, out_row, out_col, sample_h, sample_w
    input  logic [87:0] s_axis_tdata,
    // kind
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // max_value, max_index, zero pad
    output logic [47:0] m_axis_tdata
);

    fmp_cmd_t    cmd;
    fmp_status_t status;
    logic [31:0] max_value;
    logic [11:0] max_index;

    fmp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_kind  (s_axis_tuser),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    fmp_datapath #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .pixel_row   (s_axis_tdata[5:0]),
        .pixel_col   (s_axis_tdata[11:6]),
        .pixel_value (s_axis_tdata[43:12]),
        .out_row     (s_axis_tdata[49:44]),
        .out_col     (s_axis_tdata[55:50]),
        .sample_h    (s_axis_tdata[71:56]),
        .sample_w    (s_axis_tdata[87:72]),
        .cmd         (cmd),
        .status      (status),
        .out_ready   (m_axis_tready),
        .out_valid   (m_axis_tvalid),
        .max_value   (max_value),
        .max_index   (max_index)
    );

    assign m_axis_tdata = {4'b0, max_index, max_value};

endmodule

>>> sv/fmp_checker.sv
// Port-level checks for the fractional max pool block, bound to the top level.
// Depends only on the top level's port names.
module fmp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped or changed while stalled");

    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser |=> !s_axis_tready)
        else $error("request taken while a query is in progress");

    a_query_latency: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser && !m_axis_tvalid |=> !m_axis_tvalid)
        else $error("query result appeared too early");

    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && !s_axis_tuser && !m_axis_tvalid |=> !m_axis_tvalid)
        else $error("load request produced a result");

endmodule

bind fractional_max_pool_2d_forward fmp_checker u_fmp_checker (.*);

>>> tb/testbench.sv
// Self-checking testbench for fractional_max_pool_2d_forward: it fills a corner of the plane
// store, then sends directed and random load and query requests and checks every pooled result.
// Depends on fmp_pkg and the block's RTL only.
`timescale 1ns / 100ps

module testbench;
    import fmp_pkg::*;

    class pool_scoreboard;
        bit [31:0]      plane[4096];
        bit [6:0]       regs[6];
        bit [43:0]      pending_maxima[$];
        int             errors;

        function new();
            regs[CFG_IN_HEIGHT]  = 64;
            regs[CFG_IN_WIDTH]   = 64;
            regs[CFG_OUT_HEIGHT] = 32;
            regs[CFG_OUT_WIDTH]  = 32;
            regs[CFG_WIN_HEIGHT] = 2;
            regs[CFG_WIN_WIDTH]  = 2;
            errors = 0;
        endfunction

        function longint unsigned sat(longint unsigned v, longint unsigned hi);
            if (v == 0)
                return 1;
            return (v > hi) ? hi : v;
        endfunction

        function bit is_nan(bit [31:0] x);
            return x[30:0] > 31'h7F800000;
        endfunction

        function bit [31:0] order_key(bit [31:0] x);
            return x[31] ? ~x : (x | 32'h80000000);
        endfunction

        function longint unsigned start_of(longint unsigned u, longint unsigned idx,
                                           longint unsigned n_in, longint unsigned n_out,
                                           longint unsigned k);
            longint unsigned span;
            longint unsigned den;
            if (idx >= n_out - 1)
                return n_in - k;
            span = n_in - k;
            den = 65536 * (n_out - 1);
            return ((idx * 65536 + u) * span) / den - (u * span) / den;
        endfunction

        function void note_request(bit kind, bit [87:0] d);
            longint unsigned ih, iw, oh, ow, kh, kw, sh, sw, best_idx;
            bit [31:0] best;
            bit [31:0] v;
            bit        take;
            if (kind == KIND_LOAD)
            begin
                plane[{d[5:0], d[11:6]}] = d[43:12];
                return;
            end
            ih = sat(regs[CFG_IN_HEIGHT], 64);
            iw = sat(regs[CFG_IN_WIDTH], 64);
            oh = sat(regs[CFG_OUT_HEIGHT], 127);
            ow = sat(regs[CFG_OUT_WIDTH], 127);
            kh = sat(regs[CFG_WIN_HEIGHT], ih);
            kw = sat(regs[CFG_WIN_WIDTH], iw);
            sh = start_of(d[71:56], d[49:44], ih, oh, kh);
            sw = start_of(d[87:72], d[55:50], iw, ow, kw);
            best = NEG_INF;
            best_idx = sh * iw + sw;
            for (longint unsigned h = sh; h < sh + kh; h++)
            begin
                for (longint unsigned w = sw; w < sw + kw; w++)
                begin
                    v = plane[h * 64 + w];
                    take = is_nan(v);
                    if (!is_nan(v) && !is_nan(best) && !(v[30:0] == 0 && best[30:0] == 0))
                        take = take || (order_key(v) > order_key(best));
                    if (take)
                    begin
                        best = v;
                        best_idx = h * iw + w;
                    end
                end
            end
            pending_maxima.push_back({best_idx[11:0], best});
        endfunction

        function void check_result(bit [47:0] d);
            bit [43:0] exp_r;
            if (pending_maxima.size() == 0)
            begin
                $display("%0t: unexpected result value=%h index=%0d", $time, d[31:0], d[43:32]);
                errors++;
                return;
            end
            exp_r = pending_maxima.pop_front();
            if (d[31:0] !== exp_r[31:0])
            begin
                $display("%0t: max_value expected %h actual %h", $time, exp_r[31:0], d[31:0]);
                errors++;
            end
            if (d[43:32] !== exp_r[43:32])
            begin
                $display("%0t: max_index expected %0d actual %0d", $time, exp_r[43:32],
                         d[43:32]);
                errors++;
            end
        endfunction
    endclass

    localparam int WATCHDOG_LIMIT = 40000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_addr = '0;
    logic [6:0]  cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [87:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;

    pool_scoreboard sb = new();
    bit             idle_on = 1'b1;
    int             stall_left = 0;
    int             quiet_cycles = 0;

    fractional_max_pool_2d_forward dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_addr(cfg_addr),
        .cfg_wdata(cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(0, 11);
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);
        if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[fractional_max_pool_2d_forward] ERROR");
            $finish;
        end
    end

    function automatic bit [31:0] pick_pixel();
        case ($urandom_range(0, 9))
            0: return 32'h7FC00000 | $urandom_range(0, 255);
            1: return 32'hFF800000;
            2: return 32'h7F800000;
            3: return {1'($urandom_range(0, 1)), 31'h0};
            4: return 32'h3F800000;
            default: return $urandom;
        endcase
    endfunction

    task automatic send(bit kind, bit [87:0] d);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= d;
        do @(posedge clk); while (!s_axis_tready);
        sb.note_request(kind, d);
    endtask

    task automatic load_pixel(int r, int c, bit [31:0] v);
        bit [87:0] d;
        d = 88'({$urandom, $urandom, $urandom});
        d[5:0] = 6'(r);
        d[11:6] = 6'(c);
        d[43:12] = v;
        send(KIND_LOAD, d);
    endtask

    task automatic query(int r, int c, int uh, int uw);
        bit [87:0] d;
        d = 88'({$urandom, $urandom, $urandom});
        d[49:44] = 6'(r);
        d[55:50] = 6'(c);
        d[71:56] = 16'(uh);
        d[87:72] = 16'(uw);
        send(KIND_QUERY, d);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending_maxima.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic set_sizes(int ih, int iw, int oh, int ow, int kh, int kw);
        int vals[6];
        vals = '{ih, iw, oh, ow, kh, kw};
        drain();
        for (int i = 0; i < 6; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_addr  <= 3'(i);
            cfg_wdata <= 7'(vals[i]);
            sb.regs[i] = 7'(vals[i]);
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_query();
        int uh;
        int uw;
        uh = $urandom_range(0, 65535);
        uw = $urandom_range(0, 65535);
        if ($urandom_range(0, 7) == 0)
            uh = $urandom_range(0, 1) ? 65535 : 0;
        if ($urandom_range(0, 7) == 0)
            uw = $urandom_range(0, 1) ? 65535 : 0;
        query($urandom_range(0, 63), $urandom_range(0, 63), uh, uw);
    endtask

    initial
    begin
        int ih, iw;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < 1024; i++)
            load_pixel(i / 32, i % 32, pick_pixel());
        for (int i = 62; i < 64; i++)
            for (int j = 62; j < 64; j++)
                load_pixel(i, j, pick_pixel());

        query(0, 0, 0, 0);
        query(63, 63, 65535, 65535);
        query(7, 5, 40000, 1234);

        set_sizes(64, 64, 63, 63, 2, 2);
        for (int i = 0; i < 2; i++)
            for (int j = 0; j < 2; j++)
                load_pixel(i, j, 32'hFF800000);
        query(0, 0, 0, 0);
        load_pixel(2, 2, 32'h7FC00001);
        load_pixel(3, 3, 32'hFFC00002);
        query(2, 2, 0, 0);
        load_pixel(4, 4, 32'h3F800000);
        load_pixel(4, 5, 32'h3F800000);
        load_pixel(5, 4, 32'h80000000);
        load_pixel(5, 5, 32'h00000000);
        query(4, 4, 0, 0);
        load_pixel(6, 6, 32'h80000000);
        load_pixel(6, 7, 32'h00000000);
        load_pixel(7, 6, 32'h80000000);
        load_pixel(7, 7, 32'h00000000);
        query(6, 6, 0, 0);

        set_sizes(0, 0, 0, 0, 0, 0);
        query(63, 0, 65535, 0);
        set_sizes(127, 20, 127, 127, 2, 127);
        query(0, 63, 0, 65535);
        set_sizes(32, 32, 1, 1, 70, 3);
        query(5, 9, 100, 200);

        for (int phase = 0; phase < 4; phase++)
        begin
            if (phase == 3)
                idle_on = 1'b0;
            ih = $urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 32);
            iw = $urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 32);
            set_sizes(ih, iw, $urandom_range(0, 127), $urandom_range(0, 70),
                      $urandom_range(0, 6), $urandom_range(1, 6));
            for (int n = 0; n < 250; n++)
            begin
                if (phase == 1 && n == 125)
                    drain();
                if ($urandom_range(0, 9) < 4)
                    load_pixel($urandom_range(0, 63), $urandom_range(0, 63), pick_pixel());
                else
                    random_query();
            end
        end

        drain();
        repeat (100) @(posedge clk);
        if (sb.errors == 0)
            $display("[fractional_max_pool_2d_forward] OK");
        else
            $display("[fractional_max_pool_2d_forward] ERROR");
        $finish;
    end

endmodule
